### rtl/core/lfu_pkg.sv
// Shared constants and types for the LFU cache policy block.
`timescale 1ns / 1ps
package lfu_pkg;
	localparam int CAPACITY = 16;
	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int OCC_W = $clog2(CAPACITY + 1);
	localparam int CAP_W = 5;
	localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;
	localparam int DATA_W = 32;
	localparam int CNT_W = 32;
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	localparam logic OP_GET = 1'b0;
	localparam logic OP_PUT = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic             load;    // latch request, clear scan accumulators
		logic             scan;    // examine entry idx
		logic [IDX_W-1:0] idx;
		logic             commit;  // apply update, load result register
	} lfu_cmd_t;
endpackage

### rtl/core/lfu_ctrl.sv
// Controller: request sequencing, scan counter and result handshake.
`timescale 1ns / 1ps
module lfu_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output lfu_pkg::lfu_cmd_t cmd
);
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_EXEC = 3'b100
	} state_t;

	state_t state_q;
	logic [lfu_pkg::IDX_W-1:0] idx_q;
	logic out_valid_q;
	logic commit;
	logic last;

	assign last = (idx_q == lfu_pkg::IDX_W'(lfu_pkg::CAPACITY - 1));
	assign in_ready = (state_q == ST_IDLE);
	assign commit = (state_q == ST_EXEC) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;

	assign cmd.load = in_valid && in_ready;
	assign cmd.scan = (state_q == ST_SCAN);
	assign cmd.idx = idx_q;
	assign cmd.commit = commit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					if (in_valid) state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					idx_q <= idx_q + 1'b1;
					if (last) state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (commit) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

### rtl/core/lfu_dp.sv
// Datapath: entry storage, scan accumulators, update and result registers.
`timescale 1ns / 1ps
module lfu_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  lfu_pkg::lfu_cmd_t                 cmd,
	input  logic                              cfg_we,
	input  logic [lfu_pkg::CAP_W-1:0]         cfg_wdata,
	input  logic                              opcode,
	input  logic signed [lfu_pkg::DATA_W-1:0] key,
	input  logic signed [lfu_pkg::DATA_W-1:0] value,
	output logic                              hit,
	output logic signed [lfu_pkg::DATA_W-1:0] read_value,
	output logic                              evicted,
	output logic signed [lfu_pkg::DATA_W-1:0] evicted_key
);
	localparam int N = lfu_pkg::CAPACITY;
	localparam int IW = lfu_pkg::IDX_W;
	localparam int DW = lfu_pkg::DATA_W;
	localparam int CW = lfu_pkg::CNT_W;

	logic [lfu_pkg::CAP_W-1:0] cap_q;
	logic [N-1:0] valid_q;
	logic [DW-1:0] key_mem [N];
	logic [DW-1:0] val_mem [N];
	logic [CW-1:0] cnt_mem [N];
	logic [IW-1:0] rank_q [N];

	// latched request
	logic op_q;
	logic [DW-1:0] key_q, val_q;

	// scan accumulators
	logic [lfu_pkg::OCC_W-1:0] used_q;
	logic m_found_q, v_found_q, f_found_q;
	logic [IW-1:0] m_idx_q, v_idx_q, f_idx_q, m_rank_q, v_rank_q;
	logic [DW-1:0] m_val_q, v_key_q;
	logic [CW-1:0] m_cnt_q, v_cnt_q;

	logic [lfu_pkg::CMP_W-1:0] cap_eff, used_x;
	logic do_raise, do_insert, do_evict;
	logic [IW-1:0] slot;
	logic s_valid;
	logic [CW-1:0] s_cnt;
	logic [IW-1:0] s_rank;
	logic better;

	always_comb begin
		if (cap_q > lfu_pkg::CAP_W'(N)) cap_eff = lfu_pkg::CMP_W'(N);
		else cap_eff = lfu_pkg::CMP_W'(cap_q);
	end
	assign used_x = lfu_pkg::CMP_W'(used_q);
	assign do_raise = m_found_q && (op_q == lfu_pkg::OP_GET || cap_eff != '0);
	assign do_insert = (op_q == lfu_pkg::OP_PUT) && (cap_eff != '0) && !m_found_q;
	assign do_evict = do_insert && (used_x >= cap_eff);
	assign slot = do_evict ? v_idx_q : f_idx_q;

	assign s_valid = valid_q[cmd.idx];
	assign s_cnt = cnt_mem[cmd.idx];
	assign s_rank = rank_q[cmd.idx];
	assign better = !v_found_q || (s_cnt < v_cnt_q) ||
		((s_cnt == v_cnt_q) && (s_rank > v_rank_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= lfu_pkg::CAP_RESET;
			valid_q <= '0;
		end else begin
			if (cfg_we) cap_q <= cfg_wdata;
			if (cmd.commit && do_insert) valid_q[slot] <= 1'b1;
		end
	end

	// scan and request registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= opcode;
			key_q <= key;
			val_q <= value;
			used_q <= '0;
			m_found_q <= 1'b0;
			v_found_q <= 1'b0;
			f_found_q <= 1'b0;
			f_idx_q <= '0;
		end else if (cmd.scan) begin
			if (s_valid) begin
				used_q <= used_q + 1'b1;
				if (!m_found_q && key_mem[cmd.idx] == key_q) begin
					m_found_q <= 1'b1;
					m_idx_q <= cmd.idx;
					m_val_q <= val_mem[cmd.idx];
					m_cnt_q <= s_cnt;
					m_rank_q <= s_rank;
				end
				if (better) begin
					v_found_q <= 1'b1;
					v_idx_q <= cmd.idx;
					v_key_q <= key_mem[cmd.idx];
					v_cnt_q <= s_cnt;
					v_rank_q <= s_rank;
				end
			end else if (!f_found_q) begin
				f_found_q <= 1'b1;
				f_idx_q <= cmd.idx;
			end
		end
	end

	// entry update and result register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			hit <= m_found_q;
			if (op_q == lfu_pkg::OP_GET)
				read_value <= m_found_q ? m_val_q : '1;
			else
				read_value <= '0;
			evicted <= do_evict;
			evicted_key <= do_evict ? v_key_q : '0;

			if (do_raise) begin
				if (m_cnt_q != '1) cnt_mem[m_idx_q] <= m_cnt_q + 1'b1;
				if (op_q == lfu_pkg::OP_PUT) val_mem[m_idx_q] <= val_q;
			end
			if (do_insert) begin
				key_mem[slot] <= key_q;
				val_mem[slot] <= val_q;
				cnt_mem[slot] <= CW'(1);
			end
			for (int i = 0; i < N; i++) begin
				if (do_raise) begin
					if (IW'(i) == m_idx_q) rank_q[i] <= '0;
					else if (valid_q[i] && rank_q[i] < m_rank_q)
						rank_q[i] <= rank_q[i] + 1'b1;
				end else if (do_insert) begin
					if (IW'(i) == slot) rank_q[i] <= '0;
					else if (valid_q[i]) begin
						if (do_evict && rank_q[i] > v_rank_q) rank_q[i] <= rank_q[i];
						else rank_q[i] <= rank_q[i] + 1'b1;
					end
				end
			end
		end
	end
endmodule

### rtl/core/lfu_cache_policy.sv
// Top level of the LFU cache policy block with LRU tie-break.
`timescale 1ns / 1ps
//
//  channel   signals                                    direction
//  request   in_valid/in_ready, opcode, key, value      in
//  response  out_valid/out_ready, hit, read_value,
//            evicted, evicted_key                       out
//  config    cfg_we, cfg_wdata (capacity_in_use)        in
//
// Each request transaction accepts the request, scans the 16 entries (one
// entry per cycle through the single storage read port), then commits the
// update and loads the response register.
// Reset clears the valid marks and sets capacity to 16; entry data is not reset.
// A finished response waits in the response register; the commit cycle stalls
// only while an earlier response is still untaken.
module lfu_cache_policy (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              opcode,
	input  logic signed [lfu_pkg::DATA_W-1:0] key,
	input  logic signed [lfu_pkg::DATA_W-1:0] value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              hit,
	output logic signed [lfu_pkg::DATA_W-1:0] read_value,
	output logic                              evicted,
	output logic signed [lfu_pkg::DATA_W-1:0] evicted_key,
	input  logic                              cfg_we,
	input  logic [lfu_pkg::CAP_W-1:0]         cfg_wdata
);
	lfu_pkg::lfu_cmd_t cmd;

	// sequencing: idle -> scan 16 entries -> commit
	lfu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// storage, match/victim search and response register
	lfu_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.opcode      (opcode),
		.key         (key),
		.value       (value),
		.hit         (hit),
		.read_value  (read_value),
		.evicted     (evicted),
		.evicted_key (evicted_key)
	);

	// one transaction in flight at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while another is in flight");

	// an eviction only happens on a put of an absent key
	a_evict_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && evicted |-> !hit && read_value == '0)
		else $error("eviction reported with hit or nonzero read value");

	// a commit never overwrites a response that has not been taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !out_valid || out_ready)
		else $error("response overwritten before transfer");
endmodule
